// File: src/kmc_pkg.sv
// Shared constants, codes and control types for the k-means clustering unit.
`timescale 1ns / 1ps
package kmc_pkg;

    // Store sizes
    localparam int MAX_POINTS   = 1024;
    localparam int MAX_DIMS     = 8;
    localparam int MAX_CLUSTERS = 16;

    localparam int PW  = $clog2(MAX_POINTS);
    localparam int DW  = $clog2(MAX_DIMS);
    localparam int CW  = $clog2(MAX_CLUSTERS);
    localparam int NW  = PW + 1;
    localparam int KW  = CW + 1;
    localparam int DCW = DW + 1;

    // Field and register widths
    localparam int COORD_W  = 16;
    localparam int KCFG_W   = 5;
    localparam int RND_W    = 8;
    localparam int NCFG_W   = 11;
    localparam int DCFG_W   = 4;
    localparam int CFG_W    = 11;
    localparam int CFGIDX_W = 2;

    // Arithmetic widths
    localparam int ACC_W  = COORD_W + PW;
    localparam int CNT_W  = PW + 1;
    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_W   = 2 * COORD_W;
    localparam int DIST_W = SQ_W + DW;
    localparam int DIVC_W = $clog2(ACC_W + 1);

    // Command codes
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_ASN   = 2'd2;
    localparam logic [1:0] CMD_CEN   = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOASN = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Register indexes
    localparam logic [CFGIDX_W-1:0] REG_CLUSTERS = 2'd0;
    localparam logic [CFGIDX_W-1:0] REG_ROUNDS   = 2'd1;
    localparam logic [CFGIDX_W-1:0] REG_POINTS   = 2'd2;
    localparam logic [CFGIDX_W-1:0] REG_DIMS     = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic          idle;
        logic [PW-1:0] p;
        logic [CW-1:0] c;
        logic [DW-1:0] j;
        logic          init_rd;
        logic          asg_issue;
        logic          first_j;
        logic          last_j;
        logic          last_c;
        logic          clr_acc;
        logic          clr_cnt;
        logic          asn_rd;
        logic          cnt_inc;
        logic          upd_rd;
        logic          upd_wr;
        logic          div_rd;
        logic          div_start;
        logic          cen_wr;
        logic          set_valid;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic             start;
        logic [NW-1:0]    n_eff;
        logic [KW-1:0]    k_eff;
        logic [DCW-1:0]   d_eff;
        logic [RND_W-1:0] rounds;
        logic             cnt_zero;
        logic             div_done;
    } t_dp_stat;

endpackage

// File: src/kmc_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module kmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/kmc_div.sv
// Bit-serial signed by unsigned divider, quotient truncated toward zero.
`timescale 1ns / 1ps
module kmc_div
    import kmc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [ACC_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]        i_divisor,
    output logic                    o_done,
    output logic [COORD_W-1:0]      o_quot
);

    logic              r_busy, r_done, r_neg;
    logic [DIVC_W-1:0] r_cnt;
    logic [ACC_W-1:0]  r_q;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dvs;
    logic [CNT_W:0]    rem_sh;
    logic              fits;
    logic [ACC_W-1:0]  quot_s;

    // One quotient bit per step
    always_comb begin
        rem_sh = {r_rem, r_q[ACC_W-1]};
        fits   = (rem_sh >= {1'b0, r_dvs});
        quot_s = r_neg ? (~r_q + ACC_W'(1)) : r_q;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DIVC_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[ACC_W-1];
            r_q   <= i_dividend[ACC_W-1] ? (~i_dividend + ACC_W'(1)) : i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_cnt <= DIVC_W'(ACC_W);
        end else if (r_busy) begin
            r_rem <= fits ? CNT_W'(rem_sh - {1'b0, r_dvs}) : CNT_W'(rem_sh);
            r_q   <= {r_q[ACC_W-2:0], fits};
            r_cnt <= r_cnt - DIVC_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = quot_s[COORD_W-1:0];

endmodule

// File: src/kmc_ctrl.sv
// Sequencer for center setup, assignment, accumulation and center update.
`timescale 1ns / 1ps
module kmc_ctrl
    import kmc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INIT     = 4'd1;
    localparam logic [3:0] S_INIT_END = 4'd2;
    localparam logic [3:0] S_ASG      = 4'd3;
    localparam logic [3:0] S_DRAIN    = 4'd4;
    localparam logic [3:0] S_CLR      = 4'd5;
    localparam logic [3:0] S_U_ASN    = 4'd6;
    localparam logic [3:0] S_U_CNT    = 4'd7;
    localparam logic [3:0] S_U_RD     = 4'd8;
    localparam logic [3:0] S_U_WR     = 4'd9;
    localparam logic [3:0] S_D_CHK    = 4'd10;
    localparam logic [3:0] S_D_RD     = 4'd11;
    localparam logic [3:0] S_D_GO     = 4'd12;
    localparam logic [3:0] S_D_WAIT   = 4'd13;
    localparam logic [3:0] S_R_END    = 4'd14;

    logic [3:0]       r_state, n_state;
    logic [PW-1:0]    r_p, n_p;
    logic [CW-1:0]    r_c, n_c;
    logic [DW-1:0]    r_j, n_j;
    logic [RND_W-1:0] r_rnd, n_rnd;
    logic [1:0]       r_drain, n_drain;
    logic             last_j, last_c, last_p, full_j, full_c;

    always_comb begin
        last_j = ({1'b0, r_j} == i_stat.d_eff - DCW'(1));
        last_c = ({1'b0, r_c} == i_stat.k_eff - KW'(1));
        last_p = ({1'b0, r_p} == i_stat.n_eff - NW'(1));
        full_j = &r_j;
        full_c = &r_c;
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_p     = r_p;
        n_c     = r_c;
        n_j     = r_j;
        n_rnd   = r_rnd;
        n_drain = r_drain;
        o_cmd   = '0;
        o_cmd.p = r_p;
        o_cmd.c = r_c;
        o_cmd.j = r_j;
        o_cmd.first_j = (r_j == '0);
        o_cmd.last_j  = last_j;
        o_cmd.last_c  = last_c;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.idle = 1'b1;
                if (i_stat.start) begin
                    n_c     = '0;
                    n_j     = '0;
                    n_rnd   = '0;
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.init_rd = 1'b1;
                n_j = r_j + DW'(1);
                if (full_j) begin
                    n_c = r_c + CW'(1);
                    if (full_c) begin
                        n_state = S_INIT_END;
                    end
                end
            end
            S_INIT_END: begin
                n_p = '0;
                n_c = '0;
                n_j = '0;
                n_state = (i_stat.rounds == '0) ? S_IDLE : S_ASG;
            end
            S_ASG: begin
                o_cmd.asg_issue = 1'b1;
                if (!last_j) begin
                    n_j = r_j + DW'(1);
                end else begin
                    n_j = '0;
                    if (!last_c) begin
                        n_c = r_c + CW'(1);
                    end else begin
                        n_c = '0;
                        if (!last_p) begin
                            n_p = r_p + PW'(1);
                        end else begin
                            n_drain = '0;
                            n_state = S_DRAIN;
                        end
                    end
                end
            end
            S_DRAIN: begin
                // Let the distance pipe write its last assignment
                n_drain = r_drain + 2'd1;
                if (r_drain == 2'd2) begin
                    n_c = '0;
                    n_j = '0;
                    n_state = S_CLR;
                end
            end
            S_CLR: begin
                o_cmd.clr_acc = 1'b1;
                o_cmd.clr_cnt = 1'b1;
                n_j = r_j + DW'(1);
                if (full_j) begin
                    n_c = r_c + CW'(1);
                    if (full_c) begin
                        n_p = '0;
                        n_state = S_U_ASN;
                    end
                end
            end
            S_U_ASN: begin
                o_cmd.asn_rd = 1'b1;
                n_state = S_U_CNT;
            end
            S_U_CNT: begin
                o_cmd.cnt_inc = 1'b1;
                n_j = '0;
                n_state = S_U_RD;
            end
            S_U_RD: begin
                o_cmd.upd_rd = 1'b1;
                n_state = S_U_WR;
            end
            S_U_WR: begin
                o_cmd.upd_wr = 1'b1;
                if (!last_j) begin
                    n_j = r_j + DW'(1);
                    n_state = S_U_RD;
                end else if (!last_p) begin
                    n_p = r_p + PW'(1);
                    n_state = S_U_ASN;
                end else begin
                    n_c = '0;
                    n_state = S_D_CHK;
                end
            end
            S_D_CHK: begin
                // Skip empty clusters, they keep their center
                n_j = '0;
                if (!i_stat.cnt_zero) begin
                    n_state = S_D_RD;
                end else if (last_c) begin
                    n_state = S_R_END;
                end else begin
                    n_c = r_c + CW'(1);
                end
            end
            S_D_RD: begin
                o_cmd.div_rd = 1'b1;
                n_state = S_D_GO;
            end
            S_D_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_D_WAIT;
            end
            S_D_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.cen_wr = 1'b1;
                    if (!last_j) begin
                        n_j = r_j + DW'(1);
                        n_state = S_D_RD;
                    end else if (!last_c) begin
                        n_c = r_c + CW'(1);
                        n_state = S_D_CHK;
                    end else begin
                        n_state = S_R_END;
                    end
                end
            end
            S_R_END: begin
                o_cmd.set_valid = 1'b1;
                n_p = '0;
                n_c = '0;
                n_j = '0;
                if (r_rnd + RND_W'(1) == i_stat.rounds) begin
                    n_state = S_IDLE;
                end else begin
                    n_rnd   = r_rnd + RND_W'(1);
                    n_state = S_ASG;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p     <= n_p;
        r_c     <= n_c;
        r_j     <= n_j;
        r_rnd   <= n_rnd;
        r_drain <= n_drain;
    end

endmodule

// File: src/kmc_dp.sv
// Datapath: stores, distance pipe, accumulators, divider and host word path.
`timescale 1ns / 1ps
module kmc_dp
    import kmc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFGIDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_command,
    input  logic [PW-1:0]             i_point_index,
    input  logic [CW-1:0]             i_cluster_index,
    input  logic [DW-1:0]             i_dim_index,
    input  logic signed [COORD_W-1:0] i_coordinate,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [COORD_W-1:0] o_read_value,
    output logic [1:0]                o_status,
    input  t_dp_cmd                   i_cmd,
    output t_dp_stat                  o_stat
);

    typedef struct packed {
        logic          v;
        logic          first_j;
        logic          last_j;
        logic          last_c;
        logic [CW-1:0] c;
        logic [PW-1:0] p;
    } t_asg_tag;

    localparam logic [1:0] K_NONE = 2'd0;
    localparam logic [1:0] K_ASN  = 2'd1;
    localparam logic [1:0] K_CEN  = 2'd2;

    // Configuration
    logic [KCFG_W-1:0] r_kcfg;
    logic [RND_W-1:0]  r_rnd;
    logic [NCFG_W-1:0] r_ncfg;
    logic [DCFG_W-1:0] r_dcfg;
    logic [NW-1:0]     n_eff;
    logic [KW-1:0]     k0, k1, k_eff;
    logic [DCW-1:0]    d_eff;

    logic r_asn_valid, r_cen_written;

    // Host path
    logic       accept, pend_mv;
    logic       r_pend_v, r_out_v;
    logic [1:0] r_pend_kind, r_pend_stat;
    logic [1:0] acc_stat, acc_kind;
    logic [COORD_W-1:0] r_out_value;
    logic [1:0]         r_out_stat;

    // RAM ports
    logic                  pt_we, pt_re;
    logic [PW+DW-1:0]      pt_addr;
    logic [COORD_W-1:0]    pt_q;
    logic                  cen_we, cen_re;
    logic [CW+DW-1:0]      cen_addr;
    logic [COORD_W-1:0]    cen_wd, cen_q;
    logic                  acc_we, acc_re;
    logic [CW+DW-1:0]      acc_addr;
    logic [ACC_W-1:0]      acc_wd, acc_q;
    logic                  asn_we, asn_re;
    logic [PW-1:0]         asn_addr;
    logic [CW-1:0]         asn_wd, asn_q;

    // Center setup
    logic          r_init_v, r_init_keep;
    logic [CW-1:0] r_init_c;
    logic [DW-1:0] r_init_j;

    // Distance pipe
    t_asg_tag                 tag0, r_tag1, r_tag2, r_tag3;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [2*DIFF_W-1:0] sq_full;
    logic [SQ_W-1:0]          r_sq;
    logic [DIST_W-1:0]        r_dist, r_best, dist_n;
    logic [CW-1:0]            r_bestc;
    logic                     better;

    // Member counts and divider
    logic [CNT_W-1:0] r_cnt [MAX_CLUSTERS];
    logic [CW-1:0]    cnt_idx;
    logic [CW-1:0]    r_cur_c;
    logic             div_done;
    logic [COORD_W-1:0] div_quot;

    // Effective counts
    always_comb begin
        if (r_ncfg == '0) begin
            n_eff = NW'(1);
        end else if (r_ncfg > NCFG_W'(MAX_POINTS)) begin
            n_eff = NW'(MAX_POINTS);
        end else begin
            n_eff = NW'(r_ncfg);
        end
        k0 = (r_kcfg == '0) ? KW'(1) : KW'(r_kcfg);
        k1 = (k0 > KW'(MAX_CLUSTERS)) ? KW'(MAX_CLUSTERS) : k0;
        k_eff = (NW'(k1) > n_eff) ? KW'(n_eff) : k1;
        if (r_dcfg == '0) begin
            d_eff = DCW'(1);
        end else if (r_dcfg > DCFG_W'(MAX_DIMS)) begin
            d_eff = DCW'(MAX_DIMS);
        end else begin
            d_eff = DCW'(r_dcfg);
        end
    end

    // Handshake
    assign pend_mv    = !r_out_v || i_out_ready;
    assign o_in_ready = i_cmd.idle && (!r_pend_v || pend_mv);
    assign accept     = i_in_valid && o_in_ready;

    // Classify the accepted word
    always_comb begin
        acc_stat = ST_OK;
        acc_kind = K_NONE;
        unique case (i_command)
            CMD_LOAD, CMD_START: begin
                acc_stat = ST_OK;
            end
            CMD_ASN: begin
                if ({1'b0, i_point_index} >= n_eff) begin
                    acc_stat = ST_RANGE;
                end else if (!r_asn_valid) begin
                    acc_stat = ST_NOASN;
                end else begin
                    acc_kind = K_ASN;
                end
            end
            CMD_CEN: begin
                if ({1'b0, i_cluster_index} >= k_eff || {1'b0, i_dim_index} >= d_eff) begin
                    acc_stat = ST_RANGE;
                end else begin
                    acc_kind = K_CEN;
                end
            end
            default: begin
                acc_stat = ST_OK;
            end
        endcase
    end

    // Configuration and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kcfg        <= KCFG_W'(2);
            r_rnd         <= RND_W'(1);
            r_ncfg        <= NCFG_W'(MAX_POINTS);
            r_dcfg        <= DCFG_W'(MAX_DIMS);
            r_asn_valid   <= 1'b0;
            r_cen_written <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_CLUSTERS: r_kcfg <= i_cfg_data[KCFG_W-1:0];
                    REG_ROUNDS:   r_rnd  <= i_cfg_data[RND_W-1:0];
                    REG_POINTS: begin
                        r_ncfg      <= i_cfg_data[NCFG_W-1:0];
                        r_asn_valid <= 1'b0;
                    end
                    REG_DIMS:     r_dcfg <= i_cfg_data[DCFG_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (accept && i_command == CMD_START) begin
                r_asn_valid   <= 1'b0;
                r_cen_written <= 1'b1;
            end else if (i_cmd.set_valid) begin
                r_asn_valid <= 1'b1;
            end
        end
    end

    // Pending and output words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (accept) begin
                r_pend_v <= 1'b1;
            end else if (pend_mv) begin
                r_pend_v <= 1'b0;
            end
            if (r_pend_v && pend_mv) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_kind <= acc_kind;
            r_pend_stat <= acc_stat;
        end
        if (r_pend_v && pend_mv) begin
            r_out_stat <= r_pend_stat;
            if (r_pend_kind == K_ASN) begin
                r_out_value <= {{(COORD_W-CW){1'b0}}, asn_q};
            end else if (r_pend_kind == K_CEN && r_cen_written) begin
                r_out_value <= cen_q;
            end else begin
                r_out_value <= '0;
            end
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_read_value = r_out_value;
    assign o_status     = r_out_stat;

    // Point store port
    always_comb begin
        pt_we = accept && i_command == CMD_LOAD;
        pt_re = i_cmd.init_rd || i_cmd.asg_issue || i_cmd.upd_rd;
        if (i_cmd.idle) begin
            pt_addr = {i_point_index, i_dim_index};
        end else if (i_cmd.init_rd) begin
            pt_addr = {PW'(i_cmd.c), i_cmd.j};
        end else begin
            pt_addr = {i_cmd.p, i_cmd.j};
        end
    end

    // Center store port
    always_comb begin
        cen_we = r_init_v || i_cmd.cen_wr;
        cen_re = i_cmd.asg_issue || (accept && i_command == CMD_CEN);
        cen_wd = r_init_v ? (r_init_keep ? pt_q : '0) : div_quot;
        if (r_init_v) begin
            cen_addr = {r_init_c, r_init_j};
        end else if (i_cmd.idle) begin
            cen_addr = {i_cluster_index, i_dim_index};
        end else begin
            cen_addr = {i_cmd.c, i_cmd.j};
        end
    end

    // Accumulator port
    always_comb begin
        acc_we   = i_cmd.clr_acc || i_cmd.upd_wr;
        acc_re   = i_cmd.upd_rd || i_cmd.div_rd;
        acc_wd   = i_cmd.clr_acc ? '0
                 : ACC_W'(acc_q + {{(ACC_W-COORD_W){pt_q[COORD_W-1]}}, pt_q});
        acc_addr = (i_cmd.upd_rd || i_cmd.upd_wr) ? {r_cur_c, i_cmd.j} : {i_cmd.c, i_cmd.j};
    end

    // Assignment store port
    always_comb begin
        asn_re = i_cmd.asn_rd || (accept && i_command == CMD_ASN);
        if (asn_we) begin
            asn_addr = r_tag3.p;
        end else if (i_cmd.idle) begin
            asn_addr = i_point_index;
        end else begin
            asn_addr = i_cmd.p;
        end
    end

    kmc_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS * MAX_DIMS)) u_pt_ram (
        .i_clk(i_clk), .i_we(pt_we), .i_re(pt_re), .i_addr(pt_addr),
        .i_wdata(i_coordinate), .o_rdata(pt_q)
    );

    kmc_ram #(.WIDTH(COORD_W), .DEPTH(MAX_CLUSTERS * MAX_DIMS)) u_cen_ram (
        .i_clk(i_clk), .i_we(cen_we), .i_re(cen_re), .i_addr(cen_addr),
        .i_wdata(cen_wd), .o_rdata(cen_q)
    );

    kmc_ram #(.WIDTH(ACC_W), .DEPTH(MAX_CLUSTERS * MAX_DIMS)) u_acc_ram (
        .i_clk(i_clk), .i_we(acc_we), .i_re(acc_re), .i_addr(acc_addr),
        .i_wdata(acc_wd), .o_rdata(acc_q)
    );

    kmc_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_asn_ram (
        .i_clk(i_clk), .i_we(asn_we), .i_re(asn_re), .i_addr(asn_addr),
        .i_wdata(asn_wd), .o_rdata(asn_q)
    );

    // Center setup write follows the point read in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_v <= 1'b0;
        end else begin
            r_init_v <= i_cmd.init_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_init_c    <= i_cmd.c;
        r_init_j    <= i_cmd.j;
        r_init_keep <= ({1'b0, i_cmd.c} < k_eff) && ({1'b0, i_cmd.j} < d_eff);
    end

    // Distance pipe tags
    always_comb begin
        tag0.v       = i_cmd.asg_issue;
        tag0.first_j = i_cmd.first_j;
        tag0.last_j  = i_cmd.last_j;
        tag0.last_c  = i_cmd.last_c;
        tag0.c       = i_cmd.c;
        tag0.p       = i_cmd.p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
        end else begin
            r_tag1 <= tag0;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
        end
    end

    // Difference, square, then accumulate and pick the nearest center
    assign sq_full = r_diff * r_diff;

    always_comb begin
        dist_n = (r_tag3.first_j ? '0 : r_dist) + DIST_W'(r_sq);
        better = (r_tag3.c == '0) || (dist_n < r_best);
        asn_we = r_tag3.v && r_tag3.last_j && r_tag3.last_c;
        asn_wd = better ? r_tag3.c : r_bestc;
    end

    always_ff @(posedge i_clk) begin
        r_diff <= DIFF_W'($signed(cen_q)) - DIFF_W'($signed(pt_q));
        r_sq   <= sq_full[SQ_W-1:0];
        if (r_tag3.v) begin
            r_dist <= dist_n;
            if (r_tag3.last_j && better) begin
                r_best  <= dist_n;
                r_bestc <= r_tag3.c;
            end
        end
    end

    // Member counts
    assign cnt_idx = i_cmd.cnt_inc ? asn_q : i_cmd.c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_cnt) begin
            for (int i = 0; i < MAX_CLUSTERS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_cmd.cnt_inc) begin
            r_cnt[cnt_idx] <= r_cnt[cnt_idx] + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_inc) begin
            r_cur_c <= asn_q;
        end
    end

    kmc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ($signed(acc_q)),
        .i_divisor  (r_cnt[cnt_idx]),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Status to the controller
    always_comb begin
        o_stat.start    = accept && i_command == CMD_START;
        o_stat.n_eff    = n_eff;
        o_stat.k_eff    = k_eff;
        o_stat.d_eff    = d_eff;
        o_stat.rounds   = r_rnd;
        o_stat.cnt_zero = (r_cnt[cnt_idx] == '0);
        o_stat.div_done = div_done;
    end

endmodule

// File: src/kmeans_lloyd_clustering_unit.sv
// Loads, reads: result word passes a pending then an output register after accept,
// one word per cycle sustained while the receiver stays ready. Start: busy through
// setup and all rounds, one distance term per cycle, center divider one bit a step.
// Synchronous active-low reset clears control, configuration to defaults,
// centers read as zero, no assignment; point and assignment contents undefined.
`timescale 1ns / 1ps
module kmeans_lloyd_clustering_unit
    import kmc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFGIDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_command,
    input  logic [PW-1:0]             i_point_index,
    input  logic [CW-1:0]             i_cluster_index,
    input  logic [DW-1:0]             i_dim_index,
    input  logic signed [COORD_W-1:0] i_coordinate,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [COORD_W-1:0] o_read_value,
    output logic [1:0]                o_status
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    kmc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    kmc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_point_index   (i_point_index),
        .i_cluster_index (i_cluster_index),
        .i_dim_index     (i_dim_index),
        .i_coordinate    (i_coordinate),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_read_value    (o_read_value),
        .o_status        (o_status),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat)
    );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the k-means clustering unit: loads, starts and read-backs.
`timescale 1ns / 1ps
module tb_top;
    import kmc_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [COORD_W-1:0] value;
        logic [1:0]         status;
    } t_result;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      cfg_we;
    logic [CFGIDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic [1:0]                command;
    logic [PW-1:0]             point_index;
    logic [CW-1:0]             cluster_index;
    logic [DW-1:0]             dim_index;
    logic signed [COORD_W-1:0] coordinate;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [COORD_W-1:0] read_value;
    logic [1:0]                status;

    // Shadow state of the unit
    logic signed [COORD_W-1:0] point_mem [MAX_POINTS][MAX_DIMS];
    logic signed [COORD_W-1:0] center_mem [MAX_CLUSTERS][MAX_DIMS];
    logic [CW-1:0]             label_mem [MAX_POINTS];
    logic                      labels_valid;
    int unsigned               k_reg, rounds_reg, n_reg, d_reg;

    t_result     pending_results [$];
    int          error_count;
    int          words_sent;
    int          cycle_count;
    bit          steady;
    bit          hold_req;
    logic signed [COORD_W-1:0] seed_pos [MAX_CLUSTERS][MAX_DIMS];

    kmeans_lloyd_clustering_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_command       (command),
        .i_point_index   (point_index),
        .i_cluster_index (cluster_index),
        .i_dim_index     (dim_index),
        .i_coordinate    (coordinate),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_read_value    (read_value),
        .o_status        (status)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Effective counts after saturation
    function automatic int unsigned n_eff();
        if (n_reg == 0) return 1;
        return (n_reg > MAX_POINTS) ? MAX_POINTS : n_reg;
    endfunction

    function automatic int unsigned d_eff();
        if (d_reg == 0) return 1;
        return (d_reg > MAX_DIMS) ? MAX_DIMS : d_reg;
    endfunction

    function automatic int unsigned k_eff();
        int unsigned k;
        k = (k_reg == 0) ? 1 : k_reg;
        if (k > MAX_CLUSTERS) k = MAX_CLUSTERS;
        if (k > n_eff()) k = n_eff();
        return k;
    endfunction

    // Seed the centers, then run the assign and mean-update rounds
    function automatic void cluster_points();
        int unsigned n, d, k;
        longint      sums [MAX_CLUSTERS][MAX_DIMS];
        int unsigned members [MAX_CLUSTERS];
        longint      best, dsq, diff;
        n = n_eff();
        d = d_eff();
        k = k_eff();
        for (int c = 0; c < MAX_CLUSTERS; c++)
            for (int j = 0; j < MAX_DIMS; j++)
                center_mem[c][j] = (c < k && j < d) ? point_mem[c][j] : '0;
        labels_valid = 1'b0;
        for (int r = 0; r < rounds_reg; r++) begin
            for (int p = 0; p < n; p++) begin
                best = 0;
                for (int c = 0; c < k; c++) begin
                    dsq = 0;
                    for (int j = 0; j < d; j++) begin
                        diff = longint'(center_mem[c][j]) - longint'(point_mem[p][j]);
                        dsq += diff * diff;
                    end
                    if (c == 0 || dsq < best) begin
                        best = dsq;
                        label_mem[p] = CW'(c);
                    end
                end
            end
            for (int c = 0; c < MAX_CLUSTERS; c++) begin
                members[c] = 0;
                for (int j = 0; j < MAX_DIMS; j++) sums[c][j] = 0;
            end
            for (int p = 0; p < n; p++) begin
                members[label_mem[p]]++;
                for (int j = 0; j < d; j++)
                    sums[label_mem[p]][j] += longint'(point_mem[p][j]);
            end
            // empty clusters keep their old center
            for (int c = 0; c < k; c++) begin
                if (members[c] != 0)
                    for (int j = 0; j < d; j++)
                        center_mem[c][j] = COORD_W'(sums[c][j] / longint'(members[c]));
            end
            labels_valid = 1'b1;
        end
    endfunction

    // Work out the result word of one accepted command
    function automatic t_result predict_word(logic [1:0] cmd, logic [PW-1:0] pi,
                                             logic [CW-1:0] ci, logic [DW-1:0] di,
                                             logic signed [COORD_W-1:0] coord);
        t_result res;
        res.value  = '0;
        res.status = ST_OK;
        case (cmd)
            CMD_LOAD:  point_mem[pi][di] = coord;
            CMD_START: cluster_points();
            CMD_ASN: begin
                if (pi >= n_eff()) res.status = ST_RANGE;
                else if (!labels_valid) res.status = ST_NOASN;
                else res.value = COORD_W'(label_mem[pi]);
            end
            default: begin
                if (ci >= k_eff() || di >= d_eff()) res.status = ST_RANGE;
                else res.value = center_mem[ci][di];
            end
        endcase
        return res;
    endfunction

    // Offer one word, hold it until accepted, then record its expected result
    task automatic send_word(logic [1:0] cmd, int unsigned pi, int unsigned ci,
                             int unsigned di, logic signed [COORD_W-1:0] coord);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        point_index   <= PW'(pi);
        cluster_index <= CW'(ci);
        dim_index     <= DW'(di);
        coordinate    <= coord;
        do @(posedge i_clk); while (!in_ready);
        pending_results.insert(pending_results.size(),
                               predict_word(cmd, PW'(pi), CW'(ci), DW'(di), coord));
        words_sent++;
    endtask

    // Drop valid and wait until every expected word has come back and the unit is idle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0 || !in_ready) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFGIDX_W-1:0] idx, int unsigned data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(data);
        @(posedge i_clk);
        case (idx)
            REG_CLUSTERS: k_reg = data & 32'h1F;
            REG_ROUNDS:   rounds_reg = data & 32'hFF;
            REG_POINTS: begin
                n_reg = data & 32'h7FF;
                labels_valid = 1'b0;
            end
            default:      d_reg = data & 32'hF;
        endcase
    endtask

    task automatic configure(int unsigned k, int unsigned r, int unsigned n, int unsigned d);
        write_reg(REG_CLUSTERS, k);
        write_reg(REG_ROUNDS, r);
        write_reg(REG_POINTS, n);
        write_reg(REG_DIMS, d);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord();
        return COORD_W'($urandom_range(0, 16'hFFFF));
    endfunction

    // Load every used coordinate of the first points around a few seed positions
    task automatic load_points(int unsigned n, int unsigned groups);
        logic signed [COORD_W-1:0] v;
        int g;
        for (int c = 0; c < groups; c++)
            for (int j = 0; j < MAX_DIMS; j++)
                seed_pos[c][j] = COORD_W'($urandom_range(0, 60000)) - 16'sd30000;
        for (int p = 0; p < n; p++) begin
            g = $urandom_range(0, groups - 1);
            for (int j = 0; j < d_eff(); j++) begin
                if ($urandom_range(0, 15) == 0) v = rand_coord();
                else v = seed_pos[g][j] + COORD_W'($urandom_range(0, 1023)) - 16'sd512;
                send_word(CMD_LOAD, p, $urandom_range(0, 15), j, v);
            end
        end
    endtask

    // Read up to 40 labels and up to 6 centers, plus two possibly out-of-range indexes
    task automatic read_back();
        for (int p = 0; p < n_eff() && p < 40; p++)
            send_word(CMD_ASN, p, $urandom, $urandom, rand_coord());
        send_word(CMD_ASN, n_eff() < MAX_POINTS ? n_eff() : $urandom, 0, 0, 0);
        for (int c = 0; c < k_eff() && c < 6; c++)
            for (int j = 0; j < d_eff(); j++)
                send_word(CMD_CEN, $urandom, c, j, rand_coord());
        send_word(CMD_CEN, $urandom, $urandom, $urandom, rand_coord());
    endtask

    task automatic test_directed();
        // defaults straight after reset
        send_word(CMD_ASN, 0, 0, 0, 0);
        send_word(CMD_CEN, 0, 1, 7, 0);
        drain();
        // tie between two extreme points goes to the lower cluster
        configure(2, 1, 3, 2);
        send_word(CMD_LOAD, 0, 0, 0, -16'sd32768);
        send_word(CMD_LOAD, 0, 0, 1, 16'sd32767);
        send_word(CMD_LOAD, 1, 0, 0, 16'sd32766);
        send_word(CMD_LOAD, 1, 0, 1, 16'sd32767);
        send_word(CMD_LOAD, 2, 0, 0, -16'sd1);
        send_word(CMD_LOAD, 2, 0, 1, 16'sd32767);
        send_word(CMD_LOAD, 1023, 0, 7, 16'sd5);
        send_word(CMD_START, 0, 0, 0, 0);
        read_back();
        send_word(CMD_CEN, 0, 0, 2, 0);
        drain();
        // empty cluster: duplicate points leave cluster one without members
        configure(3, 2, 3, 1);
        send_word(CMD_LOAD, 0, 0, 0, 16'sd5);
        send_word(CMD_LOAD, 1, 0, 0, 16'sd5);
        send_word(CMD_LOAD, 2, 0, 0, -16'sd7);
        send_word(CMD_START, 0, 0, 0, 0);
        read_back();
        drain();
        // stale labels after a point count write
        write_reg(REG_POINTS, 3);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        send_word(CMD_ASN, 1, 0, 0, 0);
        drain();
        // zero rounds, zero counts saturating to one
        configure(0, 0, 0, 0);
        send_word(CMD_START, 0, 0, 0, 0);
        read_back();
        drain();
    endtask

    task automatic test_full_size();
        // point count above the store, cluster count above the maximum
        configure(31, 1, 2047, 1);
        load_points(MAX_POINTS, 16);
        send_word(CMD_START, 0, 0, 0, 0);
        read_back();
        send_word(CMD_ASN, 1023, 0, 0, 0);
        drain();
    endtask

    task automatic test_long_rounds();
        configure(2, 255, 3, 15);
        load_points(3, 2);
        send_word(CMD_START, 0, 0, 0, 0);
        read_back();
        drain();
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        steady   = 1'b1;
        for (int i = 0; i < 40; i++)
            send_word(CMD_CEN, 0, $urandom, $urandom, 0);
        steady = 1'b0;
        drain();
    endtask

    task automatic test_random_phases();
        int unsigned n, sel;
        while (words_sent < 1800) begin
            n = $urandom_range(2, 24);
            configure($urandom_range(0, 8), $urandom_range(0, 3), n, $urandom_range(0, 15));
            steady = ($urandom_range(0, 3) == 0);
            load_points(n, $urandom_range(1, 4));
            send_word(CMD_START, 0, 0, 0, 0);
            for (int i = 0; i < 40; i++) begin
                sel = $urandom_range(0, 19);
                if (sel == 0 && i > 20)
                    send_word(CMD_START, 0, 0, 0, 0);
                else if (sel < 4)
                    send_word(CMD_LOAD, $urandom, $urandom, $urandom, rand_coord());
                else if (sel < 11)
                    send_word(CMD_ASN, (sel == 4) ? $urandom : $urandom_range(0, n - 1),
                              $urandom, $urandom, rand_coord());
                else
                    send_word(CMD_CEN, $urandom, $urandom_range(0, (sel == 11) ? 15 : 7),
                              $urandom, rand_coord());
            end
            steady = 1'b0;
            drain();
        end
    endtask

    // Receiver: random stall before each word, one long hold-off on request
    initial begin
        int wait_n;
        out_ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                wait_n = steady ? 0 : $urandom_range(0, 8);
                if (wait_n > 0) begin
                    out_ready <= 1'b0;
                    repeat (wait_n) @(posedge i_clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!out_valid && !hold_req);
        end
    end

    // Compare each returned word with the oldest expectation
    always @(posedge i_clk) begin
        t_result exp_word;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected word: read_value %0d status %0d", read_value, status);
                error_count++;
            end else begin
                exp_word = pending_results.pop_front();
                if (read_value !== exp_word.value) begin
                    $error("read_value expected %0d actual %0d",
                           $signed(exp_word.value), read_value);
                    error_count++;
                end
                if (status !== exp_word.status) begin
                    $error("status expected %0d actual %0d", exp_word.status, status);
                    error_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        command       <= CMD_LOAD;
        point_index   <= '0;
        cluster_index <= '0;
        dim_index     <= '0;
        coordinate    <= '0;
        error_count   = 0;
        words_sent    = 0;
        cycle_count   = 0;
        steady        = 1'b0;
        hold_req      = 1'b0;
        labels_valid  = 1'b0;
        k_reg         = 2;
        rounds_reg    = 1;
        n_reg         = 1024;
        d_reg         = 8;
        for (int c = 0; c < MAX_CLUSTERS; c++)
            for (int j = 0; j < MAX_DIMS; j++) center_mem[c][j] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_long_rounds();
        test_full_size();
        test_random_phases();

        drain();
        repeat (50) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected words never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: sim.f
src/kmc_pkg.sv
src/kmc_ram.sv
src/kmc_div.sv
src/kmc_ctrl.sv
src/kmc_dp.sv
src/kmeans_lloyd_clustering_unit.sv
tb/tb_top.sv
